// File: sv/bsrt_pkg.sv
// types and constants shared by the bad-sector range table
// no dependencies; imported by bsrt_cell and bad_sector_range_table_top
package bsrt_pkg;

    // byte addresses: 39-bit sector times at most 4096 bytes, plus a 36-bit length
    localparam int BW = 52;

    localparam logic [1:0] CMD_RD  = 2'd0;
    localparam logic [1:0] CMD_WR  = 2'd1;
    localparam logic [1:0] CMD_ADD = 2'd2;
    localparam logic [1:0] CMD_REM = 2'd3;

    localparam logic [1:0] KIND_PERSIST = 2'd0;
    localparam logic [1:0] KIND_TRANS   = 2'd1;
    localparam logic [1:0] KIND_FIXW    = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ERR  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_BAD  = 2'd3;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_UP   = 2'd1;
    localparam logic [1:0] CELL_DOWN = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] byte_offset;
        logic [31:0] byte_count;
        logic [38:0] start_sector;
        logic [23:0] sector_count;
        logic [7:0]  error_code;
        logic        on_reads;
        logic        on_writes;
        logic [1:0]  entry_kind;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] fail_code;
        logic [4:0] removed_count;
        logic [4:0] entries_used;
    } rsp_t;

    typedef struct packed {
        logic          valid;
        logic          rd;
        logic          wr;
        logic [1:0]    kind;
        logic [7:0]    code;
        logic [BW-1:0] bstart;
        logic [BW-1:0] bend;
    } ent_t;

    typedef struct packed {
        logic          cmp_en;
        logic          apply_en;
        logic [1:0]    move;
        logic          is_check;
        logic          wr_check;
        logic          is_remove;
        logic [BW-1:0] lo;
        logic [BW-1:0] hi;
    } cell_ctl_t;

endpackage

// File: sv/bsrt_cell.sv
// one slot of the range table: holds an entry, compares it with a byte range
// and passes hit and hole flags to its older neighbor; uses bsrt_pkg
module bsrt_cell
    import bsrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  ent_t      prev_ent,
    input  ent_t      next_ent,
    input  logic      hit_in,
    input  logic      hole_in,
    output ent_t      ent,
    output logic      hit_out,
    output logic      hole_out,
    output logic      sel,
    output logic      kill
);

    logic valid_reg;
    ent_t pay_reg;
    logic ovl_reg;
    logic hit;
    logic fixw;
    logic en;

    always_comb
    begin
        ent       = pay_reg;
        ent.valid = valid_reg;
    end

    assign hit      = valid_reg & ovl_reg;
    assign fixw     = ctl.wr_check && (pay_reg.kind == KIND_FIXW);
    assign en       = ctl.wr_check ? pay_reg.wr : pay_reg.rd;
    assign sel      = ctl.is_check && hit && !hit_in && !fixw && en;
    // write checks clear fix-on-write entries only ahead of the first hit
    assign kill     = hit && (ctl.is_remove ||
                      (ctl.is_check && !hit_in &&
                       (fixw || (sel && pay_reg.kind == KIND_TRANS))));
    assign hit_out  = hit_in | sel;
    assign hole_out = hole_in | !valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.cmp_en)
        begin
            ovl_reg <= (ctl.lo < pay_reg.bend) && (pay_reg.bstart < ctl.hi);
        end
        case (ctl.move)
            CELL_UP:   pay_reg <= prev_ent;
            CELL_DOWN:
            begin
                if (hole_in || !valid_reg)
                begin
                    pay_reg <= next_ent;
                end
            end
            default:   pay_reg <= pay_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            case (ctl.move)
                CELL_UP:   valid_reg <= prev_ent.valid;
                CELL_DOWN:
                begin
                    if (hole_in || !valid_reg)
                    begin
                        valid_reg <= next_ent.valid;
                    end
                end
                default:
                begin
                    if (ctl.apply_en && kill)
                    begin
                        valid_reg <= 1'b0;
                    end
                end
            endcase
        end
    end

endmodule

// File: sv/bad_sector_range_table_top.sv
// bad-sector range table: a chain of bsrt_cell slots, newest entry in slot 0
// plus the command sequencer and result register; uses bsrt_pkg
//
// usage: a command item enters on req_valid/req_item while req_stall is low;
// one result item leaves on rsp_valid/rsp_item and is taken while rsp_stall
// is low. commands: read check, write check, add range, remove ranges.
// one item is worked at a time. an item passes through its steps from acceptance
// to its result (scale operands, form the range end, compare in every slot,
// apply priority pick and deletions), then the chain packs itself, closing the
// holes left by deleted entries, before the next item is taken. a result waits
// in the output register while rsp_stall is high; the apply step waits for it,
// no result is lost.
// reset clears every slot's valid bit and the entry count; the table is
// empty and ready right after reset, with no clearing pass.
module bad_sector_range_table_top
    import bsrt_pkg::*;
#(
    parameter int ENTRIES      = 16,
    parameter int SECTOR_BYTES = 512
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_item,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_item
);

    localparam int UW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_PACK  = 3'd5;

    logic [2:0]    state_reg, state_next;
    req_t          req_reg;
    logic [BW-1:0] lo_reg, len_reg, hi_reg;
    logic [UW-1:0] used_reg, used_next;
    logic          out_valid_reg;
    rsp_t          out_reg, out_next;

    cell_ctl_t     ctl;
    ent_t          ents [ENTRIES];
    ent_t          new_ent;
    ent_t          nul_ent;
    logic [ENTRIES:0]   hit_c;
    logic [ENTRIES:0]   hole_c;
    logic [ENTRIES-1:0] sel_v, kill_v, vld_v;
    logic [7:0]    fcode;
    logic [UW-1:0] nkill;
    logic          is_check, is_add, is_rem, add_bad, rem_bad, full, out_free, packed_ok;

    assign is_check = (req_reg.cmd == CMD_RD) || (req_reg.cmd == CMD_WR);
    assign is_add   = req_reg.cmd == CMD_ADD;
    assign is_rem   = req_reg.cmd == CMD_REM;
    assign add_bad  = (req_reg.sector_count == '0) || (req_reg.error_code == '0) ||
                      (req_reg.entry_kind > KIND_FIXW);
    assign rem_bad  = req_reg.sector_count == '0;
    assign full     = used_reg == UW'(ENTRIES);
    assign out_free = !out_valid_reg || !rsp_stall;

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    always_comb
    begin
        new_ent        = '0;
        new_ent.valid  = 1'b1;
        new_ent.rd     = req_reg.on_reads;
        new_ent.wr     = req_reg.on_writes;
        new_ent.kind   = req_reg.entry_kind;
        new_ent.code   = req_reg.error_code;
        new_ent.bstart = lo_reg;
        new_ent.bend   = hi_reg;
        nul_ent        = '0;
    end

    always_comb
    begin
        ctl           = '0;
        ctl.cmp_en    = state_reg == S_CMP;
        ctl.apply_en  = (state_reg == S_APPLY) && out_free &&
                        (is_check || (is_rem && !rem_bad));
        ctl.is_check  = is_check;
        ctl.wr_check  = req_reg.cmd == CMD_WR;
        ctl.is_remove = is_rem;
        ctl.lo        = lo_reg;
        ctl.hi        = hi_reg;
        if ((state_reg == S_APPLY) && out_free && is_add && !add_bad && !full)
        begin
            ctl.move = CELL_UP;
        end
        else if (state_reg == S_PACK)
        begin
            ctl.move = CELL_DOWN;
        end
        else
        begin
            ctl.move = CELL_HOLD;
        end
    end

    assign hit_c[0]  = 1'b0;
    assign hole_c[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        bsrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .prev_ent ((i == 0) ? new_ent : ents[(i == 0) ? 0 : i - 1]),
            .next_ent ((i == ENTRIES - 1) ? nul_ent : ents[(i == ENTRIES - 1) ? i : i + 1]),
            .hit_in   (hit_c[i]),
            .hole_in  (hole_c[i]),
            .ent      (ents[i]),
            .hit_out  (hit_c[i+1]),
            .hole_out (hole_c[i+1]),
            .sel      (sel_v[i]),
            .kill     (kill_v[i])
        );
        assign vld_v[i] = ents[i].valid;
    end

    // no empty slot below a used one
    assign packed_ok = ((vld_v >> 1) & ~vld_v) == '0;

    always_comb
    begin
        fcode = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            fcode = fcode | (sel_v[i] ? ents[i].code : 8'd0);
        end
    end

    assign nkill = UW'($countones(kill_v));

    always_comb
    begin
        out_next  = '0;
        used_next = used_reg;
        if (is_check)
        begin
            out_next.status    = hit_c[ENTRIES] ? STAT_ERR : STAT_OK;
            out_next.fail_code = fcode;
            used_next          = used_reg - nkill;
            out_next.removed_count = 5'(nkill);
        end
        else if (is_add)
        begin
            if (add_bad)
            begin
                out_next.status = STAT_BAD;
            end
            else if (full)
            begin
                out_next.status = STAT_FULL;
            end
            else
            begin
                used_next = used_reg + UW'(1);
            end
        end
        else
        begin
            if (rem_bad)
            begin
                out_next.status = STAT_BAD;
            end
            else
            begin
                used_next              = used_reg - nkill;
                out_next.removed_count = 5'(nkill);
            end
        end
        out_next.entries_used = 5'(used_next);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = req_valid ? S_PREP : S_IDLE;
            S_PREP:  state_next = S_SUM;
            S_SUM:   state_next = S_CMP;
            S_CMP:   state_next = S_APPLY;
            S_APPLY: state_next = out_free ? S_PACK : S_APPLY;
            S_PACK:  state_next = packed_ok ? S_IDLE : S_PACK;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            req_reg <= req_item;
        end
        if (state_reg == S_PREP)
        begin
            if (is_check)
            begin
                lo_reg  <= BW'(req_reg.byte_offset);
                len_reg <= BW'(req_reg.byte_count);
            end
            else
            begin
                lo_reg  <= BW'(req_reg.start_sector) * BW'(SECTOR_BYTES);
                len_reg <= BW'(req_reg.sector_count) * BW'(SECTOR_BYTES);
            end
        end
        if (state_reg == S_SUM)
        begin
            hi_reg <= lo_reg + len_reg;
        end
        if ((state_reg == S_APPLY) && out_free)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_APPLY) && out_free)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_packed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> packed_ok)
        else $error("table not packed while idle");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(vld_v) == int'(used_reg)))
        else $error("entry count disagrees with valid slots");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.status == STAT_ERR) |-> (rsp_item.fail_code != 8'd0))
        else $error("injected error without a code");

endmodule

// File: test/tb_top.sv
// testbench for bad_sector_range_table_top: random and directed table commands
// checked against an in-bench model of the range table; uses bsrt_pkg
module tb_top;
    import bsrt_pkg::*;

    localparam int NSLOT = 16;
    localparam int SBYTES = 512;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [38:0] ssec;
        logic [23:0] scnt;
        logic [7:0]  code;
        logic        rd;
        logic        wr;
        logic [1:0]  kind;
    } range_t;

    // models the table and holds the results it predicts
    class range_table_sb;
        range_t tbl[$];
        rsp_t   pending[$];
        int     errors;

        function bit meets(logic [63:0] ao, logic [63:0] al, logic [63:0] bo,
                           logic [63:0] bl);
            return (ao < bo + bl) && (bo < ao + al);
        endfunction

        function void note_request(req_t r);
            rsp_t   res;
            range_t e;
            bit     kill[$];
            range_t kept[$];
            logic [63:0] eo, el;
            res = '0;
            kill = {};
            foreach (tbl[i]) kill.push_back(1'b0);
            if (r.cmd == CMD_RD || r.cmd == CMD_WR) begin
                foreach (tbl[i]) begin
                    eo = 64'(tbl[i].ssec) * SBYTES;
                    el = 64'(tbl[i].scnt) * SBYTES;
                    if (!meets(64'(r.byte_offset), 64'(r.byte_count), eo, el))
                        continue;
                    if (r.cmd == CMD_WR && tbl[i].kind == KIND_FIXW) begin
                        kill[i] = 1'b1;
                        continue;
                    end
                    if (!(r.cmd == CMD_WR ? tbl[i].wr : tbl[i].rd))
                        continue;
                    res.status = STAT_ERR;
                    res.fail_code = tbl[i].code;
                    if (tbl[i].kind == KIND_TRANS)
                        kill[i] = 1'b1;
                    break;
                end
            end else if (r.cmd == CMD_ADD) begin
                if (r.sector_count == 0 || r.error_code == 0 || r.entry_kind > KIND_FIXW)
                    res.status = STAT_BAD;
                else if (tbl.size() >= NSLOT)
                    res.status = STAT_FULL;
                else begin
                    e.ssec = r.start_sector;
                    e.scnt = r.sector_count;
                    e.code = r.error_code;
                    e.rd = r.on_reads;
                    e.wr = r.on_writes;
                    e.kind = r.entry_kind;
                    tbl.push_front(e);
                    kill.push_front(1'b0);
                end
            end else begin
                if (r.sector_count == 0)
                    res.status = STAT_BAD;
                else
                    foreach (tbl[i])
                        if (meets(64'(r.start_sector) * SBYTES,
                                  64'(r.sector_count) * SBYTES,
                                  64'(tbl[i].ssec) * SBYTES,
                                  64'(tbl[i].scnt) * SBYTES))
                            kill[i] = 1'b1;
            end
            kept = {};
            foreach (tbl[i])
                if (kill[i])
                    res.removed_count++;
                else
                    kept.push_back(tbl[i]);
            tbl = kept;
            res.entries_used = 5'(tbl.size());
            pending.push_back(res);
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending: %p", got));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d want %0d", got.status, want.status));
            if (got.fail_code !== want.fail_code)
                report($sformatf("fail_code %0d want %0d", got.fail_code, want.fail_code));
            if (got.removed_count !== want.removed_count)
                report($sformatf("removed_count %0d want %0d",
                                 got.removed_count, want.removed_count));
            if (got.entries_used !== want.entries_used)
                report($sformatf("entries_used %0d want %0d",
                                 got.entries_used, want.entries_used));
        endtask

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_item;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_item;

    range_table_sb sb;
    bit calm;       // no idling on either side
    int cycles;

    bad_sector_range_table_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_item);
        rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 24);
    end

    // one item, with random idle cycles before it
    task automatic send_item(req_t r);
        while (!calm && $urandom_range(99) < 24)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic drain;
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic req_t noise_item();
        req_t r;
        r.cmd = 2'($urandom);
        r.byte_offset = {16'($urandom), 32'($urandom)};
        r.byte_count = $urandom;
        r.start_sector = {7'($urandom), 32'($urandom)};
        r.sector_count = 24'($urandom);
        r.error_code = 8'($urandom);
        r.on_reads = 1'($urandom);
        r.on_writes = 1'($urandom);
        r.entry_kind = 2'($urandom);
        return r;
    endfunction

    // commands confined to a small sector window so ranges meet often
    function automatic req_t window_item(logic [38:0] base);
        req_t r;
        r = noise_item();
        r.start_sector = base + $urandom_range(60);
        r.sector_count = (($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(1, 12)));
        r.error_code = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        r.entry_kind = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        r.byte_offset = 48'(base) * SBYTES + $urandom_range(70 * SBYTES);
        r.byte_count = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(8 * SBYTES));
        case ($urandom_range(9))
            0, 1, 2: r.cmd = CMD_ADD;
            3:       r.cmd = CMD_REM;
            4, 5, 6: r.cmd = CMD_RD;
            default: r.cmd = CMD_WR;
        endcase
        return r;
    endfunction

    function automatic req_t make_add(logic [38:0] s, logic [23:0] n, logic [7:0] c,
                                      logic rd, logic wr, logic [1:0] k);
        req_t r;
        r = '0;
        r.cmd = CMD_ADD;
        r.start_sector = s;
        r.sector_count = n;
        r.error_code = c;
        r.on_reads = rd;
        r.on_writes = wr;
        r.entry_kind = k;
        return r;
    endfunction

    function automatic req_t make_check(logic [1:0] c, logic [47:0] o, logic [31:0] n);
        req_t r;
        r = '1;
        r.cmd = c;
        r.byte_offset = o;
        r.byte_count = n;
        return r;
    endfunction

    initial
    begin
        req_t r;
        logic [38:0] base;
        sb = new();
        calm = 1'b0;
        req_valid = 1'b0;
        req_item = '0;
        @(posedge rst_n);
        @(posedge clk);

        // directed: bad arguments, each kind, extremes, zero-length request
        send_item(make_add(39'd10, 24'd0, 8'd5, 1'b1, 1'b1, KIND_PERSIST));
        send_item(make_add(39'd10, 24'd4, 8'd0, 1'b1, 1'b1, KIND_PERSIST));
        send_item(make_add(39'd10, 24'd4, 8'd5, 1'b1, 1'b1, 2'd3));
        send_item(make_add(39'd10, 24'd4, 8'd7, 1'b1, 1'b0, KIND_PERSIST));
        send_item(make_add(39'd12, 24'd4, 8'd9, 1'b1, 1'b1, KIND_TRANS));
        send_item(make_add(39'd11, 24'd1, 8'd3, 1'b0, 1'b1, KIND_FIXW));
        send_item(make_add('1, '1, 8'hff, 1'b1, 1'b1, KIND_PERSIST));
        send_item(make_check(CMD_RD, 48'd13 * SBYTES, 32'd1));
        send_item(make_check(CMD_RD, 48'd13 * SBYTES, 32'd1));
        send_item(make_check(CMD_RD, 48'd11 * SBYTES + 3, 32'd0));
        send_item(make_check(CMD_WR, 48'd10 * SBYTES, 32'd4 * SBYTES));
        send_item(make_check(CMD_RD, '1, '1));
        send_item(make_check(CMD_WR, 48'd0, 32'd0));
        r = make_add(39'd10, 24'd1, 8'd1, 1'b0, 1'b0, KIND_PERSIST);
        r.cmd = CMD_REM;
        send_item(r);
        r.sector_count = '0;
        send_item(r);
        for (int i = 0; i < 18; i++)
            send_item(make_add(39'(i * 3), 24'd2, 8'(i + 1), 1'b1, 1'b1, 2'(i % 3)));
        drain();

        // random: mostly windowed traffic, some raw noise, a calm stretch
        base = 39'd100;
        for (int i = 0; i < 1000; i++)
        begin
            calm = (i >= 300 && i < 450);
            if (i % 200 == 199)
                base = {7'($urandom), 32'($urandom)} - 39'd200;
            if (i == 600)
                drain();
            if ($urandom_range(9) == 0)
                send_item(noise_item());
            else
                send_item(window_item(base));
        end
        calm = 1'b0;
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
